[rtl/quadratic_equation_solver_macros.svh]
// Assertion helpers shared by the solver RTL
`ifndef QUADRATIC_EQUATION_SOLVER_MACROS_SVH
`define QUADRATIC_EQUATION_SOLVER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define QES_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qes: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define QES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qes: next-cycle check failed");

`endif

[rtl/qes_pkg.sv]
package qes_pkg;

   // coefficient and result formats
   localparam int IN_W     = 16;
   localparam int OUT_W    = 32;
   localparam int OUT_FRAC = 16;

   // discriminant magnitude when positive, and the square root pipeline
   localparam int D_W       = 2 * IN_W + 1;
   localparam int SQ_STAGES = (D_W + 2 * OUT_FRAC + 1) / 2;
   localparam int X_W       = 2 * SQ_STAGES;
   localparam int ROOT_W    = SQ_STAGES;

   // numerator magnitude, divisor magnitude and divider operands
   localparam int N_W   = ROOT_W + 1;
   localparam int UD_W  = IN_W + 1;
   localparam int NUM_W = N_W + 2;
   localparam int DEN_W = UD_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic [2:0] {
      KIND_IDENTITY      = 3'd0,
      KIND_CONTRADICTION = 3'd1,
      KIND_ONE_ROOT      = 3'd2,
      KIND_TWO_ROOTS     = 3'd3,
      KIND_NO_REAL       = 3'd4
   } qes_kind_type;

   // what travels with an item through the back part
   typedef struct packed {
      qes_kind_type      kind;
      logic              lin;
      logic [IN_W-1:0]   a;
      logic [IN_W-1:0]   b;
      logic [IN_W-1:0]   c;
   } qes_ctx_type;

   // queue entry: context plus discriminant (zero unless two roots)
   typedef struct packed {
      qes_ctx_type       ctx;
      logic [D_W-1:0]    d;
   } qes_item_type;

endpackage

[rtl/quadratic_equation_solver.sv]
// Channel   Ports                                   Handshake
// request   req_coef_quadratic/linear/constant      start high, busy low
// response  rsp_solution_kind/root_first/           rsp_strobe, one cycle
//           root_second/saturated
//
// One item per cycle sustained; each item passes in turn through 2 front
// stages, the queue, 34 square root stages, 1 numerator stage, 37 divider
// stages and the output register. The queue never holds more than one item,
// so latency is fixed.
// Reset is synchronous and clears all valid bits and the queue.
// The back part never stalls, so busy only rises if the queue were to fill.
`include "quadratic_equation_solver_macros.svh"

module quadratic_equation_solver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_quadratic,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_linear,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_constant,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_solution_kind,
   output logic signed [qes_pkg::OUT_W-1:0]  rsp_root_first,
   output logic signed [qes_pkg::OUT_W-1:0]  rsp_root_second,
   output logic                              rsp_saturated
);

   localparam int NS_W = qes_pkg::N_W + 1;
   localparam int Q_W  = qes_pkg::NUM_W;
   localparam logic [Q_W-1:0] Q_POS_LIM =
      {{(Q_W - qes_pkg::OUT_W + 1){1'b0}}, {(qes_pkg::OUT_W - 1){1'b1}}};
   localparam logic [Q_W-1:0] Q_NEG_LIM = Q_POS_LIM + 1'b1;
   localparam logic [qes_pkg::OUT_W-1:0] OUT_MAX = Q_POS_LIM[qes_pkg::OUT_W-1:0];
   localparam logic [qes_pkg::OUT_W-1:0] OUT_MIN = Q_NEG_LIM[qes_pkg::OUT_W-1:0];

   qes_pkg::qes_item_type        push_item, pop_item;
   logic                         push, nonempty;
   logic [qes_pkg::QCNT_W-1:0]   queue_count;

   logic                         sq_valid;
   logic [qes_pkg::ROOT_W-1:0]   sq_root;
   qes_pkg::qes_ctx_type         sq_ctx;

   logic                         p_valid_ff;
   logic [qes_pkg::N_W-1:0]      p_un_lo_ff, p_un_hi_ff, p_un_lo_in, p_un_hi_in;
   logic [qes_pkg::UD_W-1:0]     p_ud_ff, p_ud_in;
   logic                         p_neg_lo_ff, p_neg_hi_ff, p_neg_lo_in, p_neg_hi_in;
   qes_pkg::qes_ctx_type         p_ctx_ff;

   logic signed [NS_W-1:0]       base, s_ext, n_lo, n_hi, n_lin;
   logic [qes_pkg::UD_W-1:0]     abs_a, abs_b;

   logic                         dv_valid, dv_neg_lo, dv_neg_hi;
   logic [Q_W-1:0]               dv_q_lo, dv_q_hi;
   qes_pkg::qes_ctx_type         dv_ctx;

   logic [qes_pkg::OUT_W-1:0]    val_lo, val_hi, first_in, second_in;
   logic                         sat_lo, sat_hi, sat_in, swap;

   logic                         strobe_ff;
   logic [2:0]                   kind_ff;
   logic [qes_pkg::OUT_W-1:0]    first_ff, second_ff;
   logic                         sat_ff;

   // front: capture, products, classification
   qes_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_coef_quadratic (req_coef_quadratic),
      .req_coef_linear    (req_coef_linear),
      .req_coef_constant  (req_coef_constant),
      .queue_count_i      (queue_count),
      .push_o             (push),
      .item_o             (push_item)
   );

   qes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .item_i     (push_item),
      .pop_i      (nonempty),
      .nonempty_o (nonempty),
      .item_o     (pop_item),
      .count_o    (queue_count)
   );

   // back: square root of the scaled discriminant
   qes_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid_i  (nonempty),
      .in_d_i      (pop_item.d),
      .in_ctx_i    (pop_item.ctx),
      .out_valid_o (sq_valid),
      .out_root_o  (sq_root),
      .out_ctx_o   (sq_ctx)
   );

   // numerators and divisor as magnitude and sign
   always_comb begin
      base  = -(NS_W'($signed(sq_ctx.b)) <<< qes_pkg::OUT_FRAC);
      n_lin = -(NS_W'($signed(sq_ctx.c)) <<< qes_pkg::OUT_FRAC);
      s_ext = NS_W'(sq_root);
      n_lo  = base - s_ext;
      n_hi  = base + s_ext;
      abs_a = sq_ctx.a[qes_pkg::IN_W-1] ? -{1'b1, sq_ctx.a} : {1'b0, sq_ctx.a};
      abs_b = sq_ctx.b[qes_pkg::IN_W-1] ? -{1'b1, sq_ctx.b} : {1'b0, sq_ctx.b};
      if (sq_ctx.lin) begin
         p_un_lo_in  = n_lin[NS_W-1] ? qes_pkg::N_W'(-n_lin) : qes_pkg::N_W'(n_lin);
         p_un_hi_in  = p_un_lo_in;
         p_ud_in     = abs_b;
         p_neg_lo_in = n_lin[NS_W-1] ^ sq_ctx.b[qes_pkg::IN_W-1];
         p_neg_hi_in = p_neg_lo_in;
      end else begin
         p_un_lo_in  = n_lo[NS_W-1] ? qes_pkg::N_W'(-n_lo) : qes_pkg::N_W'(n_lo);
         p_un_hi_in  = n_hi[NS_W-1] ? qes_pkg::N_W'(-n_hi) : qes_pkg::N_W'(n_hi);
         p_ud_in     = {abs_a[qes_pkg::UD_W-2:0], 1'b0};
         p_neg_lo_in = n_lo[NS_W-1] ^ sq_ctx.a[qes_pkg::IN_W-1];
         p_neg_hi_in = n_hi[NS_W-1] ^ sq_ctx.a[qes_pkg::IN_W-1];
      end
   end

   always_ff @(posedge clock) begin
      p_un_lo_ff  <= p_un_lo_in;
      p_un_hi_ff  <= p_un_hi_in;
      p_ud_ff     <= p_ud_in;
      p_neg_lo_ff <= p_neg_lo_in;
      p_neg_hi_ff <= p_neg_hi_in;
      p_ctx_ff    <= sq_ctx;
   end

   qes_rdiv u_rdiv (
      .clock        (clock),
      .reset        (reset),
      .in_valid_i   (p_valid_ff),
      .in_un_lo_i   (p_un_lo_ff),
      .in_un_hi_i   (p_un_hi_ff),
      .in_ud_i      (p_ud_ff),
      .in_neg_lo_i  (p_neg_lo_ff),
      .in_neg_hi_i  (p_neg_hi_ff),
      .in_ctx_i     (p_ctx_ff),
      .out_valid_o  (dv_valid),
      .out_q_lo_o   (dv_q_lo),
      .out_q_hi_o   (dv_q_hi),
      .out_neg_lo_o (dv_neg_lo),
      .out_neg_hi_o (dv_neg_hi),
      .out_ctx_o    (dv_ctx)
   );

   // clamp, apply sign, order the roots and blank unused fields
   always_comb begin
      sat_lo = dv_neg_lo ? (dv_q_lo > Q_NEG_LIM) : (dv_q_lo > Q_POS_LIM);
      sat_hi = dv_neg_hi ? (dv_q_hi > Q_NEG_LIM) : (dv_q_hi > Q_POS_LIM);
      if (sat_lo) begin
         val_lo = dv_neg_lo ? OUT_MIN : OUT_MAX;
      end else begin
         val_lo = dv_neg_lo ? -dv_q_lo[qes_pkg::OUT_W-1:0] : dv_q_lo[qes_pkg::OUT_W-1:0];
      end
      if (sat_hi) begin
         val_hi = dv_neg_hi ? OUT_MIN : OUT_MAX;
      end else begin
         val_hi = dv_neg_hi ? -dv_q_hi[qes_pkg::OUT_W-1:0] : dv_q_hi[qes_pkg::OUT_W-1:0];
      end
      // a negative leading coefficient reverses the order of the roots
      swap = ~dv_ctx.lin & dv_ctx.a[qes_pkg::IN_W-1];
      case (dv_ctx.kind)
         qes_pkg::KIND_ONE_ROOT: begin
            first_in  = val_lo;
            second_in = '0;
            sat_in    = sat_lo;
         end
         qes_pkg::KIND_TWO_ROOTS: begin
            first_in  = swap ? val_hi : val_lo;
            second_in = swap ? val_lo : val_hi;
            sat_in    = sat_lo | sat_hi;
         end
         default: begin
            first_in  = '0;
            second_in = '0;
            sat_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         p_valid_ff <= sq_valid;
         strobe_ff  <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= dv_ctx.kind;
      first_ff  <= first_in;
      second_ff <= second_in;
      sat_ff    <= sat_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_solution_kind = kind_ff;
   assign rsp_root_first    = first_ff;
   assign rsp_root_second   = second_ff;
   assign rsp_saturated     = sat_ff;

   `QES_ASSERT_NOW(a_second_blank, clock, reset, rsp_strobe && (rsp_solution_kind != qes_pkg::KIND_TWO_ROOTS), rsp_root_second == '0)
   `QES_ASSERT_NOW(a_no_root_no_sat, clock, reset, rsp_strobe && (rsp_solution_kind == qes_pkg::KIND_IDENTITY || rsp_solution_kind == qes_pkg::KIND_CONTRADICTION || rsp_solution_kind == qes_pkg::KIND_NO_REAL), !rsp_saturated && rsp_root_first == '0)
   `QES_ASSERT_NEXT(a_div_to_out, clock, reset, dv_valid, rsp_strobe)

endmodule

[rtl/qes_front.sv]
module qes_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_quadratic,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_linear,
   input  logic signed [qes_pkg::IN_W-1:0]   req_coef_constant,
   input  logic [qes_pkg::QCNT_W-1:0]        queue_count_i,
   output logic                              push_o,
   output qes_pkg::qes_item_type             item_o
);

   localparam int PW = 2 * qes_pkg::IN_W;
   localparam int DSW = PW + 3;

   logic                            v1_ff, v2_ff;
   logic signed [qes_pkg::IN_W-1:0] a1_ff, b1_ff, c1_ff;
   logic signed [qes_pkg::IN_W-1:0] a2_ff, b2_ff, c2_ff;
   logic signed [PW-1:0]            bb_ff, ac_ff;
   logic signed [DSW-1:0]           dsc;
   logic                            accept;
   logic [qes_pkg::QCNT_W:0]        credit;
   qes_pkg::qes_kind_type           kind;
   logic                            lin;

   // room check counts items already in the two front stages
   assign credit = {1'b0, queue_count_i} + (qes_pkg::QCNT_W + 1)'(v1_ff)
                 + (qes_pkg::QCNT_W + 1)'(v2_ff);
   assign busy   = credit >= (qes_pkg::QCNT_W + 1)'(qes_pkg::QUEUE_DEPTH);
   assign accept = start & ~busy;

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   // capture, then the two products
   always_ff @(posedge clock) begin
      if (accept) begin
         a1_ff <= req_coef_quadratic;
         b1_ff <= req_coef_linear;
         c1_ff <= req_coef_constant;
      end
      a2_ff <= a1_ff;
      b2_ff <= b1_ff;
      c2_ff <= c1_ff;
      bb_ff <= b1_ff * b1_ff;
      ac_ff <= a1_ff * c1_ff;
   end

   // discriminant b*b - 4*a*c
   assign dsc = {{3{bb_ff[PW-1]}}, bb_ff} - {ac_ff[PW-1], ac_ff, 2'b00};

   // classify
   always_comb begin
      lin = 1'b0;
      if (a2_ff == '0) begin
         if (b2_ff == '0) begin
            kind = (c2_ff == '0) ? qes_pkg::KIND_IDENTITY : qes_pkg::KIND_CONTRADICTION;
         end else begin
            kind = qes_pkg::KIND_ONE_ROOT;
            lin  = 1'b1;
         end
      end else if (dsc[DSW-1]) begin
         kind = qes_pkg::KIND_NO_REAL;
      end else if (dsc == '0) begin
         kind = qes_pkg::KIND_ONE_ROOT;
      end else begin
         kind = qes_pkg::KIND_TWO_ROOTS;
      end
   end

   always_comb begin
      push_o        = v2_ff;
      item_o.ctx.kind = kind;
      item_o.ctx.lin  = lin;
      item_o.ctx.a    = a2_ff;
      item_o.ctx.b    = b2_ff;
      item_o.ctx.c    = c2_ff;
      item_o.d        = (kind == qes_pkg::KIND_TWO_ROOTS) ? dsc[qes_pkg::D_W-1:0] : '0;
   end

endmodule

[rtl/qes_queue.sv]
`include "quadratic_equation_solver_macros.svh"

module qes_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_i,
   input  qes_pkg::qes_item_type       item_i,
   input  logic                        pop_i,
   output logic                        nonempty_o,
   output qes_pkg::qes_item_type       item_o,
   output logic [qes_pkg::QCNT_W-1:0]  count_o
);

   qes_pkg::qes_item_type        mem_ff [qes_pkg::QUEUE_DEPTH];
   logic [qes_pkg::QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [qes_pkg::QCNT_W-1:0]   count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_in    = push_i ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop_i ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + qes_pkg::QCNT_W'(push_i) - qes_pkg::QCNT_W'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ff] <= item_i;
      end
   end

   assign item_o     = mem_ff[rd_ff];
   assign nonempty_o = count_ff != '0;
   assign count_o    = count_ff;

   `QES_ASSERT_NOW(a_no_overflow, clock, reset, push_i && !pop_i, count_ff < qes_pkg::QCNT_W'(qes_pkg::QUEUE_DEPTH))
   `QES_ASSERT_NOW(a_no_underflow, clock, reset, pop_i, count_ff != '0)

endmodule

[rtl/qes_sqrt.sv]
module qes_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid_i,
   input  logic [qes_pkg::D_W-1:0]       in_d_i,
   input  qes_pkg::qes_ctx_type          in_ctx_i,
   output logic                          out_valid_o,
   output logic [qes_pkg::ROOT_W-1:0]    out_root_o,
   output qes_pkg::qes_ctx_type          out_ctx_o
);

   localparam int S  = qes_pkg::SQ_STAGES;
   localparam int RW = qes_pkg::ROOT_W + 4;

   logic [S:0]                      valid_ff;
   logic [qes_pkg::X_W-1:0]         x_ff    [S+1];
   logic [RW-1:0]                   rem_ff  [S+1];
   logic [qes_pkg::ROOT_W-1:0]      root_ff [S+1];
   qes_pkg::qes_ctx_type            ctx_ff  [S+1];
   logic [RW-1:0]                   rem_in  [S];
   logic [qes_pkg::ROOT_W-1:0]      root_in [S];
   logic [RW-1:0]                   part    [S];
   logic [RW-1:0]                   trial   [S];

   // one result bit per stage: bring down two bits, try (root*4 + 1)
   always_comb begin
      for (int k = 0; k < S; k++) begin
         part[k]  = {rem_ff[k][RW-3:0], x_ff[k][qes_pkg::X_W-1 -: 2]};
         trial[k] = {2'b00, root_ff[k], 2'b01};
         if (part[k] >= trial[k]) begin
            rem_in[k]  = part[k] - trial[k];
            root_in[k] = {root_ff[k][qes_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = part[k];
            root_in[k] = {root_ff[k][qes_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[S-1:0], in_valid_i};
      end
   end

   // radicand is d with 2 * OUT_FRAC zero bits appended, so the root has OUT_FRAC fraction bits
   always_ff @(posedge clock) begin
      x_ff[0]    <= qes_pkg::X_W'({in_d_i, {(2 * qes_pkg::OUT_FRAC){1'b0}}});
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      ctx_ff[0]  <= in_ctx_i;
      for (int k = 0; k < S; k++) begin
         x_ff[k+1]    <= {x_ff[k][qes_pkg::X_W-3:0], 2'b00};
         rem_ff[k+1]  <= rem_in[k];
         root_ff[k+1] <= root_in[k];
         ctx_ff[k+1]  <= ctx_ff[k];
      end
   end

   assign out_valid_o = valid_ff[S];
   assign out_root_o  = root_ff[S];
   assign out_ctx_o   = ctx_ff[S];

endmodule

[rtl/qes_rdiv.sv]
module qes_rdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid_i,
   input  logic [qes_pkg::N_W-1:0]       in_un_lo_i,
   input  logic [qes_pkg::N_W-1:0]       in_un_hi_i,
   input  logic [qes_pkg::UD_W-1:0]      in_ud_i,
   input  logic                          in_neg_lo_i,
   input  logic                          in_neg_hi_i,
   input  qes_pkg::qes_ctx_type          in_ctx_i,
   output logic                          out_valid_o,
   output logic [qes_pkg::NUM_W-1:0]     out_q_lo_o,
   output logic [qes_pkg::NUM_W-1:0]     out_q_hi_o,
   output logic                          out_neg_lo_o,
   output logic                          out_neg_hi_o,
   output qes_pkg::qes_ctx_type          out_ctx_o
);

   // q = (2n + d) / (2d): round to nearest, ties away from zero
   localparam int S  = qes_pkg::NUM_W;
   localparam int DW = qes_pkg::DEN_W;

   logic [S:0]                   valid_ff;
   logic [qes_pkg::NUM_W-1:0]    numq_ff [S+1][2];
   logic [DW-1:0]                rem_ff  [S+1][2];
   logic [DW-1:0]                den_ff  [S+1];
   logic [1:0]                   neg_ff  [S+1];
   qes_pkg::qes_ctx_type         ctx_ff  [S+1];
   logic [qes_pkg::NUM_W-1:0]    numq_in [S][2];
   logic [DW-1:0]                rem_in  [S][2];
   logic [DW:0]                  part    [S][2];
   logic [DW:0]                  diff    [S][2];

   // restoring division, one quotient bit per stage and lane
   always_comb begin
      for (int k = 0; k < S; k++) begin
         for (int l = 0; l < 2; l++) begin
            part[k][l] = {rem_ff[k][l], numq_ff[k][l][qes_pkg::NUM_W-1]};
            diff[k][l] = part[k][l] - {1'b0, den_ff[k]};
            if (part[k][l] >= {1'b0, den_ff[k]}) begin
               rem_in[k][l]  = diff[k][l][DW-1:0];
               numq_in[k][l] = {numq_ff[k][l][qes_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in[k][l]  = part[k][l][DW-1:0];
               numq_in[k][l] = {numq_ff[k][l][qes_pkg::NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[S-1:0], in_valid_i};
      end
   end

   always_ff @(posedge clock) begin
      numq_ff[0][0] <= {in_un_lo_i, 1'b0} + qes_pkg::NUM_W'(in_ud_i);
      numq_ff[0][1] <= {in_un_hi_i, 1'b0} + qes_pkg::NUM_W'(in_ud_i);
      rem_ff[0][0]  <= '0;
      rem_ff[0][1]  <= '0;
      den_ff[0]     <= {in_ud_i, 1'b0};
      neg_ff[0]     <= {in_neg_hi_i, in_neg_lo_i};
      ctx_ff[0]     <= in_ctx_i;
      for (int k = 0; k < S; k++) begin
         numq_ff[k+1][0] <= numq_in[k][0];
         numq_ff[k+1][1] <= numq_in[k][1];
         rem_ff[k+1][0]  <= rem_in[k][0];
         rem_ff[k+1][1]  <= rem_in[k][1];
         den_ff[k+1]     <= den_ff[k];
         neg_ff[k+1]     <= neg_ff[k];
         ctx_ff[k+1]     <= ctx_ff[k];
      end
   end

   assign out_valid_o  = valid_ff[S];
   assign out_q_lo_o   = numq_ff[S][0];
   assign out_q_hi_o   = numq_ff[S][1];
   assign out_neg_lo_o = neg_ff[S][0];
   assign out_neg_hi_o = neg_ff[S][1];
   assign out_ctx_o    = ctx_ff[S];

endmodule

[tb/quadratic_equation_solver_test.sv]
module quadratic_equation_solver_test;

   // one predicted result item
   typedef struct {
      qes_pkg::qes_kind_type kind;
      logic signed [31:0]    root_lo;
      logic signed [31:0]    root_hi;
      logic                  clamped;
   } solution_type;

   // predicts solutions of accepted equations and checks the response stream
   class solution_board;
      solution_type pending[$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  kind_seen[5];

      // n / d, nearest, ties away from zero
      function automatic longint div_round(longint n, longint d);
         longint un, ud, q;
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         q  = (2 * un + ud) / (2 * ud);
         return ((n < 0) != (d < 0)) ? -q : q;
      endfunction

      function automatic logic signed [31:0] clip32(longint v, inout logic flag);
         if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
         end
         if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      // floor(sqrt(disc * 2^32))
      function automatic longint root_of_disc(longint disc);
         logic [127:0] x, r, cand;
         x = 128'(disc) << 32;
         r = '0;
         for (int bit_idx = 48; bit_idx >= 0; bit_idx--) begin
            cand = r | (128'd1 << bit_idx);
            if (cand * cand <= x) r = cand;
         end
         return longint'(r[63:0]);
      endfunction

      function void note(logic signed [15:0] qa, logic signed [15:0] qb,
                         logic signed [15:0] qc);
         solution_type e;
         longint a, b, c, disc, s, lo, hi, t;
         a = qa; b = qb; c = qc;
         e.kind = qes_pkg::KIND_IDENTITY; e.root_lo = 0; e.root_hi = 0; e.clamped = 1'b0;
         if (a == 0) begin
            if (b == 0) begin
               e.kind = (c == 0) ? qes_pkg::KIND_IDENTITY : qes_pkg::KIND_CONTRADICTION;
            end else begin
               e.kind = qes_pkg::KIND_ONE_ROOT;
               e.root_lo = clip32(div_round(-c * 65536, b), e.clamped);
            end
         end else begin
            disc = b * b - 4 * a * c;
            if (disc < 0) begin
               e.kind = qes_pkg::KIND_NO_REAL;
            end else if (disc == 0) begin
               e.kind = qes_pkg::KIND_ONE_ROOT;
               e.root_lo = clip32(div_round(-b * 65536, 2 * a), e.clamped);
            end else begin
               s  = root_of_disc(disc);
               lo = div_round(-b * 65536 - s, 2 * a);
               hi = div_round(-b * 65536 + s, 2 * a);
               if (lo > hi) begin
                  t = lo; lo = hi; hi = t;
               end
               e.kind = qes_pkg::KIND_TWO_ROOTS;
               e.root_lo = clip32(lo, e.clamped);
               e.root_hi = clip32(hi, e.clamped);
            end
         end
         pending.push_back(e);
      endfunction

      function void check(logic [2:0] kind, logic signed [31:0] r1,
                          logic signed [31:0] r2, logic sat);
         solution_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item: kind %0d", kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.kind <= qes_pkg::KIND_NO_REAL) kind_seen[e.kind]++;
         if (kind !== e.kind) begin
            $error("solution_kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (r1 !== e.root_lo) begin
            $error("root_first: expected %0d, actual %0d", e.root_lo, r1);
            errors++;
         end
         if (r2 !== e.root_hi) begin
            $error("root_second: expected %0d, actual %0d", e.root_hi, r2);
            errors++;
         end
         if (sat !== e.clamped) begin
            $error("saturated: expected %0d, actual %0d", e.clamped, sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_coef_quadratic;
   logic signed [15:0] req_coef_linear;
   logic signed [15:0] req_coef_constant;
   logic               rsp_strobe;
   logic [2:0]         rsp_solution_kind;
   logic signed [31:0] rsp_root_first;
   logic signed [31:0] rsp_root_second;
   logic               rsp_saturated;

   solution_board board = new();
   int unsigned   sent;
   int unsigned   idle_pct;

   quadratic_equation_solver u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_coef_quadratic (req_coef_quadratic),
      .req_coef_linear    (req_coef_linear),
      .req_coef_constant  (req_coef_constant),
      .rsp_strobe         (rsp_strobe),
      .rsp_solution_kind  (rsp_solution_kind),
      .rsp_root_first     (rsp_root_first),
      .rsp_root_second    (rsp_root_second),
      .rsp_saturated      (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response side: every strobe is one result item
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check(rsp_solution_kind, rsp_root_first, rsp_root_second, rsp_saturated);
   end

   // present one item, idling first at random, and hold until taken
   task automatic send_item(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start              <= 1'b1;
      req_coef_quadratic <= a;
      req_coef_linear    <= b;
      req_coef_constant  <= c;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.note(a, b, c);
      sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // random equation, mostly shaped towards the interesting cases
   task automatic send_random;
      logic signed [15:0] a, b, c;
      int m, x, y;
      a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
      case ($urandom_range(7))
         0: a = 16'sd0;
         1: begin
            a = 16'sd0; b = $urandom_range(1) ? 16'sd0 : b;
         end
         2: b = 16'sd0;
         3: c = 16'sd0;
         4: begin
            // repeated root: b^2 = 4ac
            m = $urandom_range(1, 8); x = $urandom_range(1, 15); y = $urandom_range(0, 15);
            a = 16'(($urandom_range(1) ? -m : m) * x * x);
            c = 16'((a < 0 ? -m : m) * y * y);
            b = 16'(($urandom_range(1) ? -2 : 2) * m * x * y);
         end
         5: begin
            a = $signed(16'($urandom_range(0, 15))) - 16'sd8;
            b = $signed(16'($urandom_range(0, 255))) - 16'sd128;
            c = $signed(16'($urandom_range(0, 255))) - 16'sd128;
         end
         default: ;
      endcase
      send_item(a, b, c);
   endtask

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      start = 1'b0;
      req_coef_quadratic = '0;
      req_coef_linear = '0;
      req_coef_constant = '0;
      reset = 1'b1;
      sent = 0;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: each case and the coefficient extremes
      send_item(16'sd0, 16'sd0, 16'sd0);
      send_item(16'sd0, 16'sd0, 16'sh8000);
      send_item(16'sd0, 16'sh0100, 16'sh0200);
      send_item(16'sd0, 16'sd1, 16'sh7fff);
      send_item(16'sd0, 16'sh8000, 16'sh8000);
      send_item(16'sd0, 16'sh7fff, 16'sh8000);
      send_item(16'sh0100, 16'sd0, 16'shfc00);
      send_item(16'sh0100, 16'sd0, 16'sh0400);
      send_item(16'sh0100, 16'sh0300, 16'sd0);
      send_item(16'sh0100, 16'shfe00, 16'sh0100);
      send_item(16'sh0100, 16'sd0, 16'sd0);
      send_item(16'sh0100, 16'shfd00, 16'sh0200);
      send_item(16'sd1, 16'sh7fff, 16'sh8000);
      send_item(16'sd1, 16'sh8000, 16'sh7fff);
      send_item(16'shffff, 16'sh8000, 16'sh8000);
      send_item(16'sh8000, 16'sh7fff, 16'sh7fff);
      send_item(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(16'sh8000, 16'sh8000, 16'sh8000);
      send_item(16'sh7fff, 16'sd1, 16'sh8000);
      send_item(16'shffff, 16'sd0, 16'sh7fff);
      send_item(16'sd1, 16'sd2, 16'sd1);
      send_item(16'shffff, 16'sd1, 16'sd0);
      drain();

      // random phases at differing sender idle rates
      for (int p = 0; p < 4; p++) begin
         idle_pct = (p == 1) ? 52 : (p == 3) ? 31 : 0;
         repeat (410) send_random();
         if (p == 1) drain();
      end
      drain();

      $display("Sent %0d equations, checked %0d results", sent, board.checked);
      $display("Kinds identity/contradiction/one/two/none: %0d %0d %0d %0d %0d",
               board.kind_seen[0], board.kind_seen[1], board.kind_seen[2],
               board.kind_seen[3], board.kind_seen[4]);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/qes_pkg.sv
rtl/qes_front.sv
rtl/qes_queue.sv
rtl/qes_sqrt.sv
rtl/qes_rdiv.sv
rtl/quadratic_equation_solver.sv
tb/quadratic_equation_solver_test.sv
